FILE: src/pbi_pkg.sv
// shared types and constants for the partition bitmap index
// no dependencies
package pbi_pkg;

    localparam int NUM_PARTITIONS_DEF = 1024;
    localparam int INDEX_BITS_DEF     = 10;

    localparam logic [1:0] FUNC_LOOKUP  = 2'd0;
    localparam logic [1:0] FUNC_FIND    = 2'd1;
    localparam logic [1:0] FUNC_COMMIT  = 2'd2;
    localparam logic [1:0] FUNC_MIGRATE = 2'd3;

    localparam logic [1:0] REG_ZEROTH  = 2'd0;
    localparam logic [1:0] REG_SERVERS = 2'd1;
    localparam logic [1:0] REG_MODE    = 2'd2;
    localparam logic [1:0] REG_BUCKETS = 2'd3;

    localparam logic [1:0] MODE_ALWAYS  = 2'd0;
    localparam logic [1:0] MODE_BOUNDED = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_ABSENT = 2'd1;
    localparam logic [1:0] STATUS_NOFREE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LK_RD,
        ST_LK_CHK,
        ST_FS_RD,
        ST_FS_CHK,
        ST_CH_RD,
        ST_CH_CHK,
        ST_MUL,
        ST_MOD_INIT,
        ST_MOD,
        ST_OUT
    } state_t;

endpackage

FILE: src/pbi_ram.sv
// generic single-port ram with registered read
// no dependencies
module pbi_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry a cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: src/partition_bitmap_index.sv
// Partition bitmap index: keeps which hash partitions exist and answers lookup,
// find-split-child, commit-split and migration-check requests, one at a time.
// After reset a clearing pass sweeps the presence memory before the first item is
// taken. Lookup and find-split walk the memory one entry per probe, each probe a
// read state and a check state: lookup makes at most INDEX_BITS+1 probes, find-split
// reads and checks the parent, then each child probed, ends in the child read state
// when the children run out and adds a multiply state when a free child is found.
// Every item then passes a setup state, the compare-subtract steps of the server
// modulo and an output state. The next input can be taken in the cycle after the
// result transfer.
// depends on pbi_pkg, pbi_ram
module partition_bitmap_index (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_func,
    input  logic [9:0]            s_hash_bits,
    input  logic [9:0]            s_part_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [9:0]            m_result_index,
    output logic [7:0]            m_server,
    output logic                  m_flag,
    output logic [1:0]            m_status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [10:0]           cfg_data
);

    localparam int NUM_PARTITIONS = pbi_pkg::NUM_PARTITIONS_DEF;
    localparam int AW = $clog2(NUM_PARTITIONS);

    pbi_pkg::state_t state_reg, state_next;

    logic [7:0]  zeroth_reg;
    logic [8:0]  servers_reg;
    logic [1:0]  mode_reg;
    logic [10:0] buckets_reg;
    logic [9:0]  highest_reg, highest_next;

    logic [1:0]  func_reg, func_next;
    logic [9:0]  hash_reg, hash_next;
    logic [9:0]  part_reg, part_next;
    logic [16:0] idx_reg, idx_next;
    logic [4:0]  bit_reg, bit_next;
    logic [9:0]  res_reg, res_next;
    logic        flag_reg, flag_next;
    logic [1:0]  status_reg, status_next;
    logic [19:0] bound_reg, bound_next;
    logic [10:0] rem_reg, rem_next;
    logic [3:0]  step_reg, step_next;
    logic [AW:0] clr_reg, clr_next;
    logic        mvalid_reg, mvalid_next;

    logic          ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0] ram_addr;

    logic [8:0] cnt_eff;
    logic [4:0] hp_len, idx_len, part_len;
    logic [20:0] div_shift;

    pbi_ram #(.WIDTH(1), .DEPTH(NUM_PARTITIONS)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    function automatic logic [4:0] blen(input logic [16:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int k = 0; k < 17; k++) begin
            if (v[k]) n = 5'(k + 1);
        end
        return n;
    endfunction

    // effective server count, clamped to 1..256
    always_comb begin
        cnt_eff = servers_reg;
        if (servers_reg == 9'd0) cnt_eff = 9'd1;
        if (servers_reg > 9'd256) cnt_eff = 9'd256;
    end

    assign hp_len    = blen({7'd0, highest_reg});
    assign idx_len   = blen(idx_reg);
    assign part_len  = blen({7'd0, part_reg});
    // server count shifted to the weight of the current quotient bit
    assign div_shift = {12'd0, cnt_eff} << (4'd10 - step_reg);

    // configuration registers
    assign cfg_ready = (state_reg == pbi_pkg::ST_IDLE) && !mvalid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zeroth_reg  <= 8'd0;
            servers_reg <= 9'd1;
            mode_reg    <= 2'd0;
            buckets_reg <= 11'd16;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pbi_pkg::REG_ZEROTH:  zeroth_reg  <= cfg_data[7:0];
                pbi_pkg::REG_SERVERS: servers_reg <= cfg_data[8:0];
                pbi_pkg::REG_MODE:    mode_reg    <= cfg_data[1:0];
                pbi_pkg::REG_BUCKETS: buckets_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pbi_pkg::ST_CLEAR;
            clr_reg     <= '0;
            mvalid_reg  <= 1'b0;
            highest_reg <= 10'd0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            mvalid_reg  <= mvalid_next;
            highest_reg <= highest_next;
        end
        func_reg   <= func_next;
        hash_reg   <= hash_next;
        part_reg   <= part_next;
        idx_reg    <= idx_next;
        bit_reg    <= bit_next;
        res_reg    <= res_next;
        flag_reg   <= flag_next;
        status_reg <= status_next;
        bound_reg  <= bound_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
    end

    assign s_ready = (state_reg == pbi_pkg::ST_IDLE) && !mvalid_reg;
    assign m_valid = mvalid_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        mvalid_next  = mvalid_reg;
        highest_next = highest_reg;
        func_next    = func_reg;
        hash_next    = hash_reg;
        part_next    = part_reg;
        idx_next     = idx_reg;
        bit_next     = bit_reg;
        res_next     = res_reg;
        flag_next    = flag_reg;
        status_next  = status_reg;
        bound_next   = bound_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        ram_we       = 1'b0;
        ram_wdata    = 1'b0;
        ram_addr     = idx_reg[AW-1:0];

        if (mvalid_reg && m_ready) mvalid_next = 1'b0;

        unique case (state_reg)
            pbi_pkg::ST_CLEAR: begin
                ram_addr  = clr_reg[AW-1:0];
                ram_we    = 1'b1;
                ram_wdata = (clr_reg == '0);
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(NUM_PARTITIONS - 1)) state_next = pbi_pkg::ST_IDLE;
            end
            pbi_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    func_next   = s_func;
                    hash_next   = s_hash_bits;
                    part_next   = s_part_index;
                    res_next    = s_part_index;
                    flag_next   = 1'b0;
                    status_next = pbi_pkg::STATUS_OK;
                    unique case (s_func)
                        pbi_pkg::FUNC_LOOKUP: begin
                            idx_next = {7'd0, s_hash_bits
                                & 10'((17'd1 << hp_len) - 17'd1)};
                            state_next = pbi_pkg::ST_LK_RD;
                        end
                        pbi_pkg::FUNC_FIND: begin
                            idx_next   = {7'd0, s_part_index};
                            state_next = pbi_pkg::ST_FS_RD;
                        end
                        pbi_pkg::FUNC_COMMIT: begin
                            if (17'(s_part_index) < 17'(NUM_PARTITIONS)) begin
                                ram_addr  = AW'(s_part_index);
                                ram_we    = 1'b1;
                                ram_wdata = 1'b1;
                                if (s_part_index > highest_reg)
                                    highest_next = s_part_index;
                            end
                            state_next = pbi_pkg::ST_MOD_INIT;
                        end
                        default: begin
                            state_next = pbi_pkg::ST_MOD_INIT;
                        end
                    endcase
                end
            end
            pbi_pkg::ST_LK_RD: begin
                state_next = pbi_pkg::ST_LK_CHK;
            end
            pbi_pkg::ST_LK_CHK: begin
                if (idx_reg == 17'd0 || (idx_reg < 17'(NUM_PARTITIONS) && ram_rdata)) begin
                    res_next   = idx_reg[9:0];
                    state_next = pbi_pkg::ST_MOD_INIT;
                end else begin
                    idx_next   = idx_reg & ~(17'd1 << (idx_len - 5'd1));
                    state_next = pbi_pkg::ST_LK_RD;
                end
            end
            pbi_pkg::ST_FS_RD: begin
                state_next = pbi_pkg::ST_FS_CHK;
            end
            pbi_pkg::ST_FS_CHK: begin
                if (!(idx_reg < 17'(NUM_PARTITIONS) && ram_rdata)) begin
                    status_next = pbi_pkg::STATUS_ABSENT;
                    state_next  = pbi_pkg::ST_MOD_INIT;
                end else begin
                    bit_next = part_len;
                    idx_next = {7'd0, part_reg} + (17'd1 << part_len);
                    state_next = pbi_pkg::ST_CH_RD;
                end
            end
            pbi_pkg::ST_CH_RD: begin
                if (idx_reg >= 17'(NUM_PARTITIONS) || bit_reg > 5'd16) begin
                    status_next = pbi_pkg::STATUS_NOFREE;
                    state_next  = pbi_pkg::ST_MOD_INIT;
                end else begin
                    state_next = pbi_pkg::ST_CH_CHK;
                end
            end
            pbi_pkg::ST_CH_CHK: begin
                if (!ram_rdata) begin
                    res_next   = idx_reg[9:0];
                    bound_next = buckets_reg * {2'd0, cnt_eff};
                    state_next = pbi_pkg::ST_MUL;
                end else begin
                    bit_next   = bit_reg + 5'd1;
                    idx_next   = {7'd0, part_reg} + (17'd1 << (bit_reg + 5'd1));
                    state_next = pbi_pkg::ST_CH_RD;
                end
            end
            pbi_pkg::ST_MUL: begin
                if (mode_reg == pbi_pkg::MODE_ALWAYS) flag_next = 1'b1;
                else if (mode_reg == pbi_pkg::MODE_BOUNDED)
                    flag_next = ({3'd0, idx_reg} < bound_reg);
                state_next = pbi_pkg::ST_MOD_INIT;
            end
            pbi_pkg::ST_MOD_INIT: begin
                if (func_reg == pbi_pkg::FUNC_MIGRATE)
                    flag_next = ((hash_reg & 10'((17'd1 << part_len) - 17'd1)) == part_reg);
                rem_next   = {1'b0, res_reg} + {3'd0, zeroth_reg};
                step_next  = 4'd0;
                state_next = pbi_pkg::ST_MOD;
            end
            pbi_pkg::ST_MOD: begin
                // one compare and subtract of the shifted server count per cycle
                if ({10'd0, rem_reg} >= div_shift)
                    rem_next = rem_reg - div_shift[10:0];
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd10) state_next = pbi_pkg::ST_OUT;
            end
            pbi_pkg::ST_OUT: begin
                if (!mvalid_reg) begin
                    mvalid_next = 1'b1;
                    state_next  = pbi_pkg::ST_IDLE;
                end
            end
            default: state_next = pbi_pkg::ST_IDLE;
        endcase
    end

    assign m_result_index = res_reg;
    assign m_server       = rem_reg[7:0];
    assign m_flag         = flag_reg;
    assign m_status       = status_reg;

    // no new item while a result is pending
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("accept while result pending");
    // server below count when shown
    a_server_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_server} < cnt_eff)) else $error("server out of range");
    // result appears only after leaving the output state
    a_out_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == pbi_pkg::ST_OUT) else $error("bad result");

endmodule

FILE: sim/pbi_checker.sv
`timescale 1ns / 100ps
// checker for the partition bitmap index: tracks presence and config, predicts each result
// depends on pbi_pkg
module pbi_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [9:0]  s_hash_bits,
    input  logic [9:0]  s_part_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [9:0]  m_result_index,
    input  logic [7:0]  m_server,
    input  logic        m_flag,
    input  logic [1:0]  m_status,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [9:0] index;
        logic [7:0] server;
        logic       flag;
        logic [1:0] status;
    } answer_t;

    answer_t     answers_due[$];
    logic        present_bits[1024];
    logic [9:0]  top_part;
    logic [7:0]  zeroth;
    logic [8:0]  servers;
    logic [1:0]  mode;
    logic [10:0] buckets;

    function automatic int bitlen(int v);
        int n;
        n = 0;
        while (v != 0) begin
            n++;
            v = v >> 1;
        end
        return n;
    endfunction

    function automatic int eff_servers();
        int c;
        c = (servers == 0) ? 1 : int'(servers);
        if (c > 256) c = 256;
        return c;
    endfunction

    // work out the answer and apply any presence update
    function automatic answer_t resolve_request(logic [1:0] f, logic [9:0] h, logic [9:0] p);
        answer_t a;
        int idx, i, child;
        bit hit;
        a.index = p;
        a.flag = 1'b0;
        a.status = pbi_pkg::STATUS_OK;
        case (f)
            pbi_pkg::FUNC_LOOKUP: begin
                idx = int'(h) & ((1 << bitlen(top_part)) - 1);
                while (idx != 0 && !present_bits[idx])
                    idx = idx & ~(1 << (bitlen(idx) - 1));
                a.index = idx[9:0];
            end
            pbi_pkg::FUNC_FIND: begin
                if (!present_bits[p]) begin
                    a.status = pbi_pkg::STATUS_ABSENT;
                end else begin
                    hit = 0;
                    child = 0;
                    for (i = bitlen(p); i < 11; i++) begin
                        child = int'(p) + (1 << i);
                        if (child >= 1024) break;
                        if (!present_bits[child]) begin
                            hit = 1;
                            break;
                        end
                    end
                    if (!hit) begin
                        a.status = pbi_pkg::STATUS_NOFREE;
                    end else begin
                        a.index = child[9:0];
                        if (mode == pbi_pkg::MODE_ALWAYS) a.flag = 1'b1;
                        else if (mode == pbi_pkg::MODE_BOUNDED)
                            a.flag = child < int'(buckets) * eff_servers();
                    end
                end
            end
            pbi_pkg::FUNC_COMMIT: begin
                present_bits[p] = 1'b1;
                if (p > top_part) top_part = p;
            end
            default: begin
                a.flag = ((int'(h) & ((1 << bitlen(p)) - 1)) == int'(p));
            end
        endcase
        a.server = 8'((int'(a.index) + int'(zeroth)) % eff_servers());
        return a;
    endfunction

    // watch config, input and result transfers
    always @(posedge aclk) begin
        answer_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            foreach (present_bits[k]) present_bits[k] = 1'b0;
            present_bits[0] = 1'b1;
            top_part = '0;
            zeroth = '0;
            servers = 9'd1;
            mode = '0;
            buckets = 11'd16;
            answers_due.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pbi_pkg::REG_ZEROTH:  zeroth = cfg_data[7:0];
                    pbi_pkg::REG_SERVERS: servers = cfg_data[8:0];
                    pbi_pkg::REG_MODE:    mode = cfg_data[1:0];
                    default:              buckets = cfg_data;
                endcase
            end
            if (s_valid && s_ready)
                answers_due.push_back(resolve_request(s_func, s_hash_bits, s_part_index));
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errs++;
                end else begin
                    want = answers_due.pop_front();
                    if (want.index !== m_result_index) begin
                        $error("result_index expected %0d actual %0d", want.index, m_result_index);
                        errs++;
                    end
                    if (want.server !== m_server) begin
                        $error("server expected %0d actual %0d", want.server, m_server);
                        errs++;
                    end
                    if (want.flag !== m_flag) begin
                        $error("flag expected %0d actual %0d", want.flag, m_flag);
                        errs++;
                    end
                    if (want.status !== m_status) begin
                        $error("status expected %0d actual %0d", want.status, m_status);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
        end
        pending = answers_due.size();
    end

endmodule

FILE: sim/tb_partition_bitmap_index.sv
`timescale 1ns / 100ps
// top of the partition bitmap index testbench: clock, reset, stimulus and verdict
// depends on pbi_pkg, pbi_checker and the block itself
module tb_partition_bitmap_index;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = '0;
    logic [9:0]  s_hash_bits = '0;
    logic [9:0]  s_part_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [9:0]  m_result_index;
    logic [7:0]  m_server;
    logic        m_flag;
    logic [1:0]  m_status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    bit          calm;
    int          committed[$];

    partition_bitmap_index dut (.*);
    pbi_checker chk (.*);

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result side stalls at random, never during calm stretch
    always @(negedge aclk)
        m_ready <= calm || ($urandom_range(99) >= 9);

    // valid stays high after a transfer until the next payload or an idle cycle
    task automatic send_request(logic [1:0] f, logic [9:0] h, logic [9:0] p);
        while (!calm && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_hash_bits <= h;
        s_part_index <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (f == pbi_pkg::FUNC_COMMIT) committed.push_back(p);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_config(logic [7:0] z, logic [8:0] n, logic [1:0] m, logic [10:0] b);
        drain();
        write_reg(pbi_pkg::REG_ZEROTH, {3'b0, z});
        write_reg(pbi_pkg::REG_SERVERS, {2'b0, n});
        write_reg(pbi_pkg::REG_MODE, {9'b0, m});
        write_reg(pbi_pkg::REG_BUCKETS, b);
        cfg_valid <= 1'b0;
    endtask

    // random request, mostly on partitions already present
    task automatic random_request();
        logic [9:0] p, h;
        int r;
        r = $urandom_range(99);
        h = 10'($urandom);
        p = (committed.size() != 0 && r < 70)
            ? 10'(committed[$urandom_range(committed.size() - 1)]) : 10'($urandom);
        if (r % 4 == 2 && $urandom_range(3) != 0) p = 10'($urandom_range(63));
        send_request(2'(r % 4), h, p);
    endtask

    initial begin
        int k;
        calm = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, absent and out-of-range cases
        send_request(pbi_pkg::FUNC_LOOKUP, 10'h3FF, 10'd0);
        send_request(pbi_pkg::FUNC_FIND, 10'd0, 10'd0);
        send_request(pbi_pkg::FUNC_FIND, 10'd0, 10'h3FF);
        send_request(pbi_pkg::FUNC_MIGRATE, 10'h3FF, 10'h3FF);
        send_request(pbi_pkg::FUNC_MIGRATE, 10'd0, 10'd0);
        send_request(pbi_pkg::FUNC_COMMIT, 10'd0, 10'd1);
        send_request(pbi_pkg::FUNC_COMMIT, 10'd0, 10'd3);
        send_request(pbi_pkg::FUNC_LOOKUP, 10'h3FF, 10'd0);
        send_request(pbi_pkg::FUNC_LOOKUP, 10'h002, 10'd0);
        send_request(pbi_pkg::FUNC_FIND, 10'd0, 10'd1);
        send_request(pbi_pkg::FUNC_COMMIT, 10'd0, 10'h200);
        send_request(pbi_pkg::FUNC_FIND, 10'd0, 10'h200);
        send_request(pbi_pkg::FUNC_LOOKUP, 10'h3FF, 10'h3FF);
        send_request(pbi_pkg::FUNC_MIGRATE, 10'h155, 10'h155);
        send_request(pbi_pkg::FUNC_MIGRATE, 10'h2AA, 10'h155);

        // server count zero, mode three, zero buckets; then server count above 256 in bounded mode
        set_config(8'hFF, 9'd0, 2'd3, 11'd0);
        send_request(pbi_pkg::FUNC_FIND, 10'd0, 10'd0);
        send_request(pbi_pkg::FUNC_LOOKUP, 10'h3FF, 10'd0);
        set_config(8'hFF, 9'h1FF, pbi_pkg::MODE_BOUNDED, 11'd0);
        send_request(pbi_pkg::FUNC_FIND, 10'd0, 10'd0);
        send_request(pbi_pkg::FUNC_LOOKUP, 10'h3FF, 10'd0);

        // random phases over several settings
        for (k = 0; k < 6; k++) begin
            case (k)
                0: set_config(8'd0, 9'd256, pbi_pkg::MODE_ALWAYS, 11'd1024);
                1: set_config(8'd7, 9'd3, pbi_pkg::MODE_BOUNDED, 11'd2);
                2: set_config(8'($urandom), 9'($urandom_range(1, 256)), 2'd1, 11'd2047);
                3: set_config(8'd200, 9'd256, pbi_pkg::MODE_BOUNDED, 11'd1);
                4: set_config(8'($urandom), 9'($urandom), 2'($urandom), 11'($urandom));
                default: set_config(8'd255, 9'd1, pbi_pkg::MODE_BOUNDED, 11'd1024);
            endcase
            calm = (k == 2);
            repeat (300) random_request();
        end
        calm = 1'b0;

        // hold off until every result is in, then finish
        drain();
        if (fail_count == 0)
            $display("partition_bitmap_index test passed");
        else
            $display("partition_bitmap_index test failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("partition_bitmap_index test failed");
        $finish;
    end

endmodule
